FILE: design/affine_vertex_transform_core_defines.svh
// assertion macros shared by the checker of the affine vertex transform core
`ifndef AFFINE_VERTEX_TRANSFORM_CORE_DEFINES_SVH
`define AFFINE_VERTEX_TRANSFORM_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define AVT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("avt checker: same-cycle property failed");

// next-cycle implication, sampled on clk, quiet during reset
`define AVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("avt checker: next-cycle property failed");

`endif

FILE: design/avt_pkg.sv
// shared types and constants of the affine vertex transform core
package avt_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 4;
    localparam int NUM_ROWS  = 3;
    localparam int NUM_COLS  = 4;
    localparam int NUM_WORDS = NUM_ROWS * NUM_COLS;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SUM_W     = PROD_W + 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    // words on the diagonal of the 3x3 part hold 1.0 after reset
    localparam logic [NUM_WORDS-1:0] DIAG_MASK = 12'b0100_0010_0001;
    localparam logic [COORD_W-1:0] FIX_ONE =
        {{(COORD_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic                      opcode;
        logic [IDX_W-1:0]          element_index;
        logic signed [COORD_W-1:0] element_value;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] norm_x;
        logic signed [COORD_W-1:0] norm_y;
        logic signed [COORD_W-1:0] norm_z;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_pos_x;
        logic signed [COORD_W-1:0] out_pos_y;
        logic signed [COORD_W-1:0] out_pos_z;
        logic signed [COORD_W-1:0] out_norm_x;
        logic signed [COORD_W-1:0] out_norm_y;
        logic signed [COORD_W-1:0] out_norm_z;
        logic                      saturated;
    } out_word_t;

    // classified command between front and back
    typedef struct packed {
        logic                             is_load;
        logic [IDX_W-1:0]                 index;
        logic [COORD_W-1:0]               value;
        logic [NUM_ROWS-1:0][COORD_W-1:0] pos;
        logic [NUM_ROWS-1:0][COORD_W-1:0] norm;
    } cmd_t;

endpackage

FILE: design/avt_front.sv
// front end: accepts input words, drops bad loads, queues commands for the back end
module avt_front #(
    parameter int CMD_DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  avt_pkg::in_word_t in_data,
    output logic             full,
    output logic             cmd_valid,
    output avt_pkg::cmd_t    cmd_data,
    input  logic             cmd_pop
);

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    avt_pkg::cmd_t    queue_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    avt_pkg::cmd_t cmd_in;
    logic          keep;
    logic          wr_en;
    logic          rd_en;

    // classify: transforms always go on, loads only to a real matrix word
    always_comb
    begin
        keep = 1'b0;
        if (in_data.opcode == avt_pkg::OP_XFORM)
            keep = 1'b1;
        else if (in_data.element_index inside {[0:avt_pkg::NUM_WORDS-1]})
            keep = 1'b1;
        cmd_in.is_load = (in_data.opcode == avt_pkg::OP_LOAD);
        cmd_in.index   = in_data.element_index;
        cmd_in.value   = in_data.element_value;
        cmd_in.pos[0]  = in_data.pos_x;
        cmd_in.pos[1]  = in_data.pos_y;
        cmd_in.pos[2]  = in_data.pos_z;
        cmd_in.norm[0] = in_data.norm_x;
        cmd_in.norm[1] = in_data.norm_y;
        cmd_in.norm[2] = in_data.norm_z;
    end

    assign full      = (cnt_reg == CNT_W'(CMD_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd_data  = queue_reg[rd_ptr_reg];
    assign wr_en     = push && !full && keep;
    assign rd_en     = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

FILE: design/avt_res_fifo.sv
// result queue in front of the output port
module avt_res_fifo #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  avt_pkg::out_word_t wr_data,
    input  logic               pop,
    output logic               empty,
    output avt_pkg::out_word_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    avt_pkg::out_word_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_en;

    assign empty   = (cnt_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign rd_en   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: design/avt_back.sv
// back end: matrix store, multiply and add pipeline, rounding and saturation
module avt_back #(
    parameter int OUT_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  avt_pkg::cmd_t      cmd_data,
    output logic               cmd_pop,
    input  logic               res_pop,
    output logic               res_wr,
    output avt_pkg::out_word_t res_data
);

    localparam int NR     = avt_pkg::NUM_ROWS;
    localparam int NL     = 2 * NR;
    localparam int CW     = avt_pkg::COORD_W;
    localparam int FB     = avt_pkg::FRAC_BITS;
    localparam int PW     = avt_pkg::PROD_W;
    localparam int SW     = avt_pkg::SUM_W;
    localparam int RW     = SW - FB;
    localparam int PEND_W = $clog2(OUT_DEPTH + 1);
    localparam logic [SW-1:0] HALF = {{(SW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

    logic [CW-1:0]        mat_reg [avt_pkg::NUM_WORDS];
    logic [PEND_W-1:0]    pend_reg, pend_next;

    logic signed [PW-1:0] prod_reg [NL][NR];
    logic [CW-1:0]        trans_reg [NR];
    logic                 s1_valid_reg;

    logic signed [SW-1:0] part_a_reg [NL];
    logic signed [SW-1:0] part_b_reg [NL];
    logic                 s2_valid_reg;

    logic signed [SW-1:0] sum_reg [NL];
    logic                 s3_valid_reg;

    logic                 credit_ok;
    logic                 issue;
    logic                 issue_xform;
    logic [CW-1:0]        lane_val [NL];
    logic                 lane_sat [NL];

    // results in flight plus results waiting never exceed the result queue
    assign credit_ok   = (pend_reg < PEND_W'(OUT_DEPTH)) || res_pop;
    assign issue       = cmd_valid && (cmd_data.is_load || credit_ok);
    assign issue_xform = issue && !cmd_data.is_load;
    assign cmd_pop     = issue;

    always_comb
    begin
        pend_next = pend_reg;
        if (issue_xform && !res_pop)
            pend_next = pend_reg + 1'b1;
        else if (res_pop && !issue_xform)
            pend_next = pend_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int i = 0; i < avt_pkg::NUM_WORDS; i++)
                mat_reg[i] <= avt_pkg::DIAG_MASK[i] ? avt_pkg::FIX_ONE : '0;
        end
        else
        begin
            pend_reg     <= pend_next;
            s1_valid_reg <= issue_xform;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (issue && cmd_data.is_load)
                mat_reg[cmd_data.index] <= cmd_data.value;
        end
    end

    // stage 1: eighteen products, translation column captured with them
    always_ff @(posedge clk)
    begin
        if (issue_xform)
        begin
            for (int r = 0; r < NR; r++)
            begin
                trans_reg[r] <= mat_reg[r*avt_pkg::NUM_COLS + NR];
                for (int k = 0; k < NR; k++)
                begin
                    prod_reg[r][k] <= PW'($signed(mat_reg[r*avt_pkg::NUM_COLS + k]))
                                    * PW'($signed(cmd_data.pos[k]));
                    prod_reg[r+NR][k] <= PW'($signed(mat_reg[r*avt_pkg::NUM_COLS + k]))
                                       * PW'($signed(cmd_data.norm[k]));
                end
            end
        end
    end

    // stage 2: two partial sums per lane, rounding half folded in
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NL; j++)
            part_a_reg[j] <= SW'(prod_reg[j][0]) + SW'(prod_reg[j][1]);
        // position lanes add the translation column
        for (int j = 0; j < NR; j++)
            part_b_reg[j] <= SW'(prod_reg[j][2])
                           + SW'($signed({trans_reg[j], {FB{1'b0}}}))
                           + $signed(HALF);
        // normal lanes use the 3x3 part only
        for (int j = NR; j < NL; j++)
            part_b_reg[j] <= SW'(prod_reg[j][2]) + $signed(HALF);
    end

    // stage 3: exact lane sum
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NL; j++)
            sum_reg[j] <= part_a_reg[j] + part_b_reg[j];
    end

    // drop fraction bits, clip to the coordinate range
    always_comb
    begin
        logic [RW-1:0] rnd;
        logic [RW-CW:0] top;
        for (int j = 0; j < NL; j++)
        begin
            rnd = sum_reg[j][SW-1:FB];
            top = rnd[RW-1:CW-1];
            if ((top == '0) || (top == '1))
            begin
                lane_val[j] = rnd[CW-1:0];
                lane_sat[j] = 1'b0;
            end
            else
            begin
                lane_val[j] = rnd[RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
                lane_sat[j] = 1'b1;
            end
        end
    end

    assign res_wr              = s3_valid_reg;
    assign res_data.out_pos_x  = lane_val[0];
    assign res_data.out_pos_y  = lane_val[1];
    assign res_data.out_pos_z  = lane_val[2];
    assign res_data.out_norm_x = lane_val[3];
    assign res_data.out_norm_y = lane_val[4];
    assign res_data.out_norm_z = lane_val[5];
    assign res_data.saturated  = lane_sat[0] | lane_sat[1] | lane_sat[2]
                               | lane_sat[3] | lane_sat[4] | lane_sat[5];

endmodule

FILE: design/affine_vertex_transform_core.sv
// top level of the affine vertex transform core
// usage:
// - input channel: a word is taken when push is high and full is low; opcode
//   load writes one matrix word (index row*4+col, 12..15 ignored), opcode
//   transform carries a position and a normal
// - result channel: while empty is low the oldest result sits on out_data and
//   leaves when pop is high; only transform words make results
// - position rows add the translation column, normal rows use the 3x3 part;
//   each component is rounded to nearest and clipped, with saturated set
// - throughput: one word per clock, loads and transforms alike, set by the
//   back-end pipeline, which accepts one command every cycle while it has credit
// - a transform passes the command queue, product stage, partial sums and
//   final sum, then the result queue, before it shows on out_data
// - a load takes effect for all transforms taken after it, none before
// - when pop stays low, results pile up in the result queue; once it and the
//   pipeline hold OUT_DEPTH results, the back end waits and the command
//   queue fills until full rises
// - reset clears both queues and the pipeline and loads the identity matrix
module affine_vertex_transform_core #(
    parameter int CMD_DEPTH = 4,
    parameter int OUT_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  avt_pkg::in_word_t  in_data,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output avt_pkg::out_word_t out_data
);

    // front to back command link
    logic          cmd_valid;
    avt_pkg::cmd_t cmd_data;
    logic          cmd_pop;

    // back to result queue
    logic               res_wr;
    avt_pkg::out_word_t res_data;
    logic               res_pop;

    assign res_pop = pop && !empty;

    // classifies words and buffers them so input never waits on the multipliers
    avt_front #(
        .CMD_DEPTH(CMD_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_data  (in_data),
        .full     (full),
        .cmd_valid(cmd_valid),
        .cmd_data (cmd_data),
        .cmd_pop  (cmd_pop)
    );

    // matrix store and the three-stage arithmetic, credit-limited by the queue
    avt_back #(
        .OUT_DEPTH(OUT_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_data (cmd_data),
        .cmd_pop  (cmd_pop),
        .res_pop  (res_pop),
        .res_wr   (res_wr),
        .res_data (res_data)
    );

    // results wait here for the receiver
    avt_res_fifo #(
        .DEPTH(OUT_DEPTH)
    ) u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_wr),
        .wr_data(res_data),
        .pop    (pop),
        .empty  (empty),
        .rd_data(out_data)
    );

endmodule

FILE: design/avt_checker.sv
// port-level checker of the affine vertex transform core and its bind
`include "affine_vertex_transform_core_defines.svh"

module avt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input avt_pkg::in_word_t  in_data,
    input logic               full,
    input logic               pop,
    input logic               empty,
    input avt_pkg::out_word_t out_data
);

    logic push_acc;

    assign push_acc = push && !full && (in_data.opcode == avt_pkg::OP_XFORM
                                        || in_data.opcode == avt_pkg::OP_LOAD);

    // a waiting result stays and holds while the receiver stalls
    `AVT_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_data))

    // the command queue fills only through accepted words
    `AVT_ASSERT_NOW(a_full_needs_push, $rose(full), $past(push_acc))

    // coming out of reset the result queue is empty and the command queue is not full
    `AVT_ASSERT_NOW(a_reset_clean, $past(!rst_n), empty && !full)

endmodule

bind affine_vertex_transform_core avt_checker u_avt_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .out_data(out_data)
);
